// ----- src/lbd_pkg.sv -----
// Package for the LZSS bit-packed decompressor: shared constants, the
// controller state type and the command/status structs between controller
// and datapath. No dependencies.
package lbd_pkg;

   localparam int BYTE_W           = 8;
   localparam int LEN_W            = 24;
   localparam int RES_W            = 32;   // bit reservoir width
   localparam int FILL_W           = 6;    // holds 0..32
   localparam int FILL_LIMIT       = 24;   // above this a new byte is dropped
   localparam int LIT_TOK_BITS     = 9;    // flag + literal
   localparam int MAX_RESULTS      = 17;   // results per transaction
   localparam int N_W              = 5;    // holds 0..MAX_RESULTS
   localparam logic [BYTE_W-1:0] BLANK_BYTE = 8'h20;

   localparam int DEF_WINDOW_BITS  = 11;
   localparam int DEF_LENGTH_BITS  = 4;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DECODE,
      ST_COPY,
      ST_FLUSH
   } lbd_state_type;

   typedef struct packed {
      logic clear_we;    // write one blank entry of the clearing pass
      logic load;        // shift the accepted byte into the reservoir
      logic take_lit;    // consume a literal token and emit it
      logic take_match;  // consume a match token and set up the copy
      logic copy_read;   // issue the next window read of the copy
      logic copy_emit;   // emit the pending copy byte
      logic flush;       // hand the staged byte on as the last result
   } lbd_cmd_type;

   typedef struct packed {
      logic clear_last;  // clearing pass is at its final entry
      logic ignore;      // stream done or reservoir too full
      logic lit_ok;      // a literal token can be taken now
      logic match_ok;    // a match token can be taken now
      logic emit_ok;     // the staging slot can take a byte this cycle
      logic out_free;    // output register can be loaded this cycle
      logic stage_valid; // a byte waits in the staging slot
      logic rd_pend;     // copy read data waits to be emitted
      logic rd_left;     // copy reads remain to be issued
   } lbd_sts_type;

endpackage

// ----- src/lbd_ctrl.sv -----
// Controller state machine of the LZSS decompressor.
// Depends on lbd_pkg; drives commands to lbd_datapath from its status.
module lbd_ctrl
   import lbd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  lbd_sts_type sts,
   output lbd_cmd_type cmd
);

   lbd_state_type state_ff;
   lbd_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear_we = 1'b1;
            if (sts.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid && !sts.ignore) begin
               cmd.load = 1'b1;
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            if (sts.lit_ok) begin
               // hold until the staging slot can take the byte
               cmd.take_lit = sts.emit_ok;
            end else if (sts.match_ok) begin
               cmd.take_match = 1'b1;
               state_in       = ST_COPY;
            end else begin
               state_in = ST_FLUSH;
            end
         end
         ST_COPY: begin
            cmd.copy_emit = sts.rd_pend && sts.emit_ok;
            cmd.copy_read = sts.rd_left && (!sts.rd_pend || cmd.copy_emit);
            if (!sts.rd_left && !sts.rd_pend) begin
               state_in = ST_DECODE;
            end
         end
         ST_FLUSH: begin
            if (!sts.stage_valid) begin
               state_in = ST_IDLE;
            end else if (sts.out_free) begin
               cmd.flush = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

endmodule

// ----- src/lbd_datapath.sv -----
// Datapath of the LZSS decompressor: bit reservoir, history window memory,
// copy read pipeline, staging slot and output register.
// Depends on lbd_pkg; commanded by lbd_ctrl.
module lbd_datapath
   import lbd_pkg::*;
#(
   parameter int WINDOW_BITS = DEF_WINDOW_BITS,
   parameter int LENGTH_BITS = DEF_LENGTH_BITS
)(
   input  logic              clock,
   input  logic              reset,
   input  lbd_cmd_type       cmd,
   output lbd_sts_type       sts,
   input  logic [BYTE_W-1:0] req_tdata,
   input  logic              csr_wr_en,
   input  logic [LEN_W-1:0]  csr_wr_data,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [BYTE_W-1:0] rsp_tdata,
   output logic              rsp_tlast,
   output logic              rsp_tuser
);

   localparam int WIN_SIZE  = 1 << WINDOW_BITS;
   localparam int MATCH_MAX = (1 << LENGTH_BITS) + 1;
   localparam int TOK_BITS  = 1 + WINDOW_BITS + LENGTH_BITS;
   localparam int TW        = LENGTH_BITS + 1;   // count + 2
   localparam int SUM_W     = TW + 2;
   localparam logic [WINDOW_BITS-1:0] START_PTR = WINDOW_BITS'(WIN_SIZE - MATCH_MAX);

   logic [BYTE_W-1:0] win_mem [WIN_SIZE];

   logic [LEN_W-1:0]       len_ff;
   logic [LEN_W-1:0]       produced_ff;
   logic [RES_W-1:0]       res_ff, res_in;
   logic [FILL_W-1:0]      fill_ff, fill_in;
   logic [N_W-1:0]         n_ff;
   logic [WINDOW_BITS-1:0] wptr_ff;
   logic [WINDOW_BITS-1:0] clr_ff;
   logic [WINDOW_BITS-1:0] rd_addr_ff;
   logic [TW-1:0]          take_ff;
   logic [TW-1:0]          rd_cnt_ff;
   logic                   rd_pend_ff;
   logic [BYTE_W-1:0]      rdata_ff;
   logic                   fwd_ff;
   logic [BYTE_W-1:0]      fwd_data_ff;
   logic                   stage_valid_ff;
   logic [BYTE_W-1:0]      stage_byte_ff;
   logic                   stage_done_ff;
   logic                   out_valid_ff;
   logic [BYTE_W-1:0]      out_byte_ff;
   logic                   out_last_ff;
   logic                   out_done_ff;

   // token fields, reservoir is kept left-aligned (next bit at the top)
   logic                   flag;
   logic [BYTE_W-1:0]      lit;
   logic [WINDOW_BITS-1:0] pos;
   logic [LENGTH_BITS-1:0] cnt;
   logic [TW-1:0]          cnt2;
   logic [LEN_W-1:0]       left;
   logic [TW-1:0]          take;
   logic [SUM_W-1:0]       take_sum;
   logic                   done;
   logic                   emit;
   logic [BYTE_W-1:0]      copy_byte;
   logic [BYTE_W-1:0]      emit_byte;
   logic [LEN_W-1:0]       produced_in;
   logic                   push;

   assign flag = res_ff[RES_W-1];
   assign lit  = res_ff[RES_W-2 -: BYTE_W];
   assign pos  = res_ff[RES_W-2 -: WINDOW_BITS];
   assign cnt  = res_ff[RES_W-2-WINDOW_BITS -: LENGTH_BITS];
   assign cnt2 = TW'(cnt) + TW'(2);
   assign left = len_ff - produced_ff;
   assign take = (left < LEN_W'(cnt2)) ? left[TW-1:0] : cnt2;
   assign take_sum = SUM_W'(n_ff) + SUM_W'(take);
   assign done = (produced_ff >= len_ff);

   assign copy_byte   = fwd_ff ? fwd_data_ff : rdata_ff;
   assign emit        = cmd.take_lit || cmd.copy_emit;
   assign emit_byte   = cmd.take_lit ? lit : copy_byte;
   assign produced_in = produced_ff + LEN_W'(1);
   // stage moves to the output register on a following emit or on flush
   assign push        = (emit && stage_valid_ff) || cmd.flush;

   always_comb begin
      sts.clear_last  = (clr_ff == {WINDOW_BITS{1'b1}});
      sts.ignore      = done || (fill_ff > FILL_W'(FILL_LIMIT));
      sts.lit_ok      = flag && !done && (fill_ff >= FILL_W'(LIT_TOK_BITS))
                        && (n_ff < N_W'(MAX_RESULTS));
      sts.match_ok    = !flag && !done && (fill_ff >= FILL_W'(TOK_BITS))
                        && (take_sum <= SUM_W'(MAX_RESULTS));
      sts.out_free    = !out_valid_ff || rsp_tready;
      sts.emit_ok     = !stage_valid_ff || sts.out_free;
      sts.stage_valid = stage_valid_ff;
      sts.rd_pend     = rd_pend_ff;
      sts.rd_left     = (rd_cnt_ff != take_ff);
   end

   always_comb begin
      res_in  = res_ff;
      fill_in = fill_ff;
      if (cmd.load) begin
         res_in  = res_ff | ({req_tdata, {(RES_W-BYTE_W){1'b0}}} >> fill_ff);
         fill_in = fill_ff + FILL_W'(BYTE_W);
      end else if (cmd.take_lit) begin
         res_in  = res_ff << LIT_TOK_BITS;
         fill_in = fill_ff - FILL_W'(LIT_TOK_BITS);
      end else if (cmd.take_match) begin
         res_in  = res_ff << TOK_BITS;
         fill_in = fill_ff - FILL_W'(TOK_BITS);
      end
   end

   // window memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (cmd.clear_we) begin
         win_mem[clr_ff] <= BLANK_BYTE;
      end else if (emit) begin
         win_mem[wptr_ff] <= emit_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.copy_read) begin
         rdata_ff    <= win_mem[rd_addr_ff];
         fwd_data_ff <= emit_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff         <= '0;
         produced_ff    <= '0;
         res_ff         <= '0;
         fill_ff        <= '0;
         n_ff           <= '0;
         wptr_ff        <= START_PTR;
         clr_ff         <= '0;
         rd_addr_ff     <= '0;
         take_ff        <= '0;
         rd_cnt_ff      <= '0;
         rd_pend_ff     <= 1'b0;
         fwd_ff         <= 1'b0;
         stage_valid_ff <= 1'b0;
         out_valid_ff   <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            len_ff <= csr_wr_data;
         end
         if (cmd.clear_we) begin
            clr_ff <= clr_ff + WINDOW_BITS'(1);
         end
         res_ff  <= res_in;
         fill_ff <= fill_in;
         if (cmd.load) begin
            n_ff <= '0;
         end else if (emit) begin
            n_ff <= n_ff + N_W'(1);
         end
         if (emit) begin
            produced_ff <= produced_in;
            wptr_ff     <= wptr_ff + WINDOW_BITS'(1);
         end
         if (cmd.take_match) begin
            rd_addr_ff <= pos;
            take_ff    <= take;
            rd_cnt_ff  <= '0;
         end else if (cmd.copy_read) begin
            rd_addr_ff <= rd_addr_ff + WINDOW_BITS'(1);
            rd_cnt_ff  <= rd_cnt_ff + TW'(1);
         end
         if (cmd.copy_read) begin
            rd_pend_ff <= 1'b1;
            // read meets the write of the previous byte: forward it
            fwd_ff     <= cmd.copy_emit && (rd_addr_ff == wptr_ff);
         end else if (cmd.copy_emit) begin
            rd_pend_ff <= 1'b0;
         end
         if (emit) begin
            stage_valid_ff <= 1'b1;
         end else if (cmd.flush) begin
            stage_valid_ff <= 1'b0;
         end
         if (push) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         stage_byte_ff <= emit_byte;
         stage_done_ff <= (produced_in == len_ff);
      end
      if (push) begin
         out_byte_ff <= stage_byte_ff;
         out_done_ff <= stage_done_ff;
         out_last_ff <= cmd.flush;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_byte_ff;
   assign rsp_tlast  = out_last_ff;
   assign rsp_tuser  = out_done_ff;

endmodule

// ----- src/lzss_bitpacked_decompressor_unit.sv -----
// LZSS bit-packed decompressor, top level.
// Depends on lbd_pkg, lbd_ctrl and lbd_datapath.
//
// Takes the packed stream one byte per transaction on req_ and reads it MSB
// first as tokens: flag 1 plus an 8-bit literal, or flag 0 plus a
// WINDOW_BITS absolute window position and a LENGTH_BITS count that copies
// count+2 bytes out of the history window (overlapping copies see bytes
// just written). Each input byte yields zero or more unpacked bytes on rsp_;
// rsp_tlast marks the last byte caused by that input byte and rsp_tuser
// marks the byte that brings the produced total to output_length
// (csr_wr_data). After that, further input bytes are accepted and dropped.
// Write output_length only while the block is idle. After reset the block
// runs a clearing pass that fills all 2^WINDOW_BITS window entries (2048 by
// default) with 0x20, one entry per cycle, with req_tready low. Each input
// byte is accepted, then tokens are decoded: a literal is taken and emitted;
// a match is set up, its first window read issued, and its bytes copied one
// per cycle from the single window read port unless the output stalls,
// then decode resumes; once no further token fits, the last byte is handed
// on. Output stalls hold each step. A dropped byte is accepted in idle.
// A new byte is accepted only once the previous one is fully decoded.
module lzss_bitpacked_decompressor_unit
   import lbd_pkg::*;
#(
   parameter int WINDOW_BITS = DEF_WINDOW_BITS,
   parameter int LENGTH_BITS = DEF_LENGTH_BITS
)(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [BYTE_W-1:0] req_tdata,    // [7:0] packed_byte
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [BYTE_W-1:0] rsp_tdata,    // [7:0] out_byte
   output logic              rsp_tlast,    // run_last
   output logic              rsp_tuser,    // [0] stream_done
   input  logic              csr_wr_en,
   input  logic [LEN_W-1:0]  csr_wr_data   // output_length
);

   lbd_cmd_type cmd;
   lbd_sts_type sts;

   // sequence token decode, copy and flush
   lbd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   // hold the reservoir, window and output register
   lbd_datapath #(
      .WINDOW_BITS (WINDOW_BITS),
      .LENGTH_BITS (LENGTH_BITS)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .sts         (sts),
      .req_tdata   (req_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .rsp_tuser   (rsp_tuser)
   );

`ifndef SYNTH
   // the byte that completes the stream always ends its transaction's run
   a_done_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> rsp_tlast)
      else $error("stream_done without run_last");

   // a loaded byte is decoded before the next one is taken
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> !req_tready)
      else $error("input accepted while a byte is in decode");

   // no byte is left staged while waiting for input
   a_idle_stage_empty: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> (!sts.stage_valid && !sts.rd_pend))
      else $error("input ready with results still in flight");

   // nothing leaves the block during the clearing pass
   a_clear_quiet: assert property (@(posedge clock) disable iff (reset)
      cmd.clear_we |-> (!rsp_tvalid && !req_tready))
      else $error("activity during window clearing");
`endif

endmodule
